// ===== rtl/fbsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbsc_pkg
// Shared types and constants for the frustum box/sphere cull block.
// ----------------------------------------------------------------------------
package fbsc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int NUM_PLANES      = 6;
    localparam int NUM_CORNERS     = 8;
    localparam int SLOT_W          = 3;
    localparam int FIELD_W         = 32;
    localparam int S_TDATA_W       = 232;
    localparam int S_TUSER_W       = 2;
    localparam int M_TDATA_W       = 8;
    localparam int FRAC_BITS       = 16;

    typedef enum logic [1:0] {
        MODE_LOAD_PLANE  = 2'd0,
        MODE_LOAD_CORNER = 2'd1,
        MODE_BOX_TEST    = 2'd2,
        MODE_SPHERE_TEST = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CAUSE_NONE   = 2'd0,
        CAUSE_PLANE  = 2'd1,
        CAUSE_CORNER = 2'd2
    } cause_t;

endpackage

// ===== rtl/frustum_box_sphere_cull.sv =====
// ----------------------------------------------------------------------------
// frustum_box_sphere_cull
// Box and sphere culling against six stored planes and eight frustum corners.
// ----------------------------------------------------------------------------
//  channel   dir  payload (low bit up)
//  s_axis    in   tuser: mode[1:0]
//                 tdata: slot[2:0] p_x p_y p_z p_w q_x q_y q_z (32 b each)
//  m_axis    out  visible[0] cull_cause[2:1]
//
//  Load items register their result at accept. After a test is accepted,
//  ST_RUN reads both RAMs, a corner row for every read address and a plane
//  row for the first six (plane products and sums overlap the reads),
//  ST_DRAIN waits until the RAM data and product stages are empty, and
//  ST_DONE registers the result once the output slot is free.
//  One item is in flight at a time; a held result stalls the input.
//  Synchronous active-low reset clears control only; RAM contents are kept.
// ----------------------------------------------------------------------------
module frustum_box_sphere_cull
    import fbsc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // mode
    input  logic [S_TUSER_W-1:0] s_tuser,
    // slot, p_x, p_y, p_z, p_w, q_x, q_y, q_z, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // visible, cull_cause, zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int W   = COORD_WIDTH;
    localparam int VW  = (W < FIELD_W) ? W : FIELD_W;
    localparam int PW  = 2 * VW;
    localparam int SW  = 2 * VW + 4;
    localparam int AW  = $clog2(NUM_CORNERS);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    cause_t cause_reg;
    logic [AW-1:0] cnt_reg;

    // input fields
    logic [S_TUSER_W-1:0] in_mode;
    logic [SLOT_W-1:0]  in_slot;
    logic signed [VW-1:0] f_px, f_py, f_pz, f_pw, f_qx, f_qy, f_qz;
    logic accept;

    assign in_mode = s_tuser;
    assign in_slot = s_tdata[SLOT_W-1:0];
    assign f_px = s_tdata[3   +: VW];
    assign f_py = s_tdata[35  +: VW];
    assign f_pz = s_tdata[67  +: VW];
    assign f_pw = s_tdata[99  +: VW];
    assign f_qx = s_tdata[131 +: VW];
    assign f_qy = s_tdata[163 +: VW];
    assign f_qz = s_tdata[195 +: VW];

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // latched test operands; for spheres the high corner equals the center
    logic signed [VW-1:0] lx_reg, ly_reg, lz_reg, hx_reg, hy_reg, hz_reg, r_reg;
    logic                 sphere_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            lx_reg     <= f_px;
            ly_reg     <= f_py;
            lz_reg     <= f_pz;
            sphere_reg <= (in_mode == MODE_SPHERE_TEST);
            if (in_mode == MODE_SPHERE_TEST) begin
                hx_reg <= f_px;
                hy_reg <= f_py;
                hz_reg <= f_pz;
                r_reg  <= f_pw;
            end else begin
                hx_reg <= f_qx;
                hy_reg <= f_qy;
                hz_reg <= f_qz;
                r_reg  <= '0;
            end
        end
    end

    // memories
    logic signed [W-1:0] wx, wy, wz, ww;
    logic                pl_we, cr_we;
    logic [AW-1:0]       pl_raddr;
    logic [4*W-1:0]      pl_rd;
    logic [3*W-1:0]      cr_rd;

    assign wx = W'(f_px);
    assign wy = W'(f_py);
    assign wz = W'(f_pz);
    assign ww = W'(f_pw);

    assign pl_we = accept && (in_mode == MODE_LOAD_PLANE)
                   && (in_slot < SLOT_W'(NUM_PLANES));
    assign cr_we = accept && (in_mode == MODE_LOAD_CORNER);
    assign pl_raddr = (cnt_reg < AW'(NUM_PLANES)) ? cnt_reg : '0;

    fbsc_ram #(.WIDTH(4 * W), .DEPTH(NUM_PLANES)) u_plane_ram (
        .aclk  (aclk),
        .we    (pl_we),
        .waddr (in_slot),
        .wdata ({ww, wz, wy, wx}),
        .raddr (pl_raddr),
        .rdata (pl_rd)
    );

    fbsc_ram #(.WIDTH(3 * W), .DEPTH(NUM_CORNERS)) u_corner_ram (
        .aclk  (aclk),
        .we    (cr_we),
        .waddr (in_slot),
        .wdata ({wz, wy, wx}),
        .raddr (cnt_reg),
        .rdata (cr_rd)
    );

    // pipeline valids: v1 = RAM data, v2 = products
    logic pv1_reg, cv1_reg, v2_reg;
    logic issuing;
    assign issuing = (state_reg == ST_RUN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv1_reg <= 1'b0;
            cv1_reg <= 1'b0;
            v2_reg  <= 1'b0;
        end else begin
            pv1_reg <= issuing && (cnt_reg < AW'(NUM_PLANES));
            cv1_reg <= issuing;
            v2_reg  <= pv1_reg;
        end
    end

    // stage 1: multiply plane coefficients by both box corners per axis
    logic signed [VW-1:0] pa, pb, pc, pd;
    logic signed [VW-1:0] cx, cy, cz;
    assign pa = pl_rd[0*W +: VW];
    assign pb = pl_rd[1*W +: VW];
    assign pc = pl_rd[2*W +: VW];
    assign pd = pl_rd[3*W +: VW];
    assign cx = cr_rd[0*W +: VW];
    assign cy = cr_rd[1*W +: VW];
    assign cz = cr_rd[2*W +: VW];

    logic signed [PW-1:0] mxl_reg, mxh_reg, myl_reg, myh_reg, mzl_reg, mzh_reg;
    logic signed [VW:0]   dr_reg;

    always_ff @(posedge aclk) begin
        mxl_reg <= pa * lx_reg;
        mxh_reg <= pa * hx_reg;
        myl_reg <= pb * ly_reg;
        myh_reg <= pb * hy_reg;
        mzl_reg <= pc * lz_reg;
        mzh_reg <= pc * hz_reg;
        dr_reg  <= (VW+1)'(pd) + (VW+1)'(r_reg);
    end

    // stage 2: largest corner value against the plane
    logic signed [PW-1:0] mx, my, mz;
    logic signed [SW-1:0] plane_sum;
    logic                 plane_out;

    assign mx = (mxh_reg > mxl_reg) ? mxh_reg : mxl_reg;
    assign my = (myh_reg > myl_reg) ? myh_reg : myl_reg;
    assign mz = (mzh_reg > mzl_reg) ? mzh_reg : mzl_reg;
    assign plane_sum = SW'(mx) + SW'(my) + SW'(mz) + (SW'(dr_reg) <<< FRAC_BITS);
    assign plane_out = sphere_reg ? (plane_sum <= 0) : (plane_sum < 0);

    logic       plane_hit_reg;
    logic [5:0] beyond_reg;   // all corners beyond +x,-x,+y,-y,+z,-z face

    always_ff @(posedge aclk) begin
        if (accept) begin
            plane_hit_reg <= 1'b0;
            beyond_reg    <= '1;
        end else begin
            if (v2_reg && plane_out) begin
                plane_hit_reg <= 1'b1;
            end
            if (cv1_reg) begin
                beyond_reg <= beyond_reg & {cz < lz_reg, cz > hz_reg,
                                            cy < ly_reg, cy > hy_reg,
                                            cx < lx_reg, cx > hx_reg};
            end
        end
    end

    cause_t test_cause;
    always_comb begin
        if (plane_hit_reg) begin
            test_cause = CAUSE_PLANE;
        end else if (!sphere_reg && (|beyond_reg)) begin
            test_cause = CAUSE_CORNER;
        end else begin
            test_cause = CAUSE_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cause_reg    <= CAUSE_NONE;
            cnt_reg      <= '0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    cnt_reg <= '0;
                    if (accept) begin
                        if (in_mode == MODE_BOX_TEST || in_mode == MODE_SPHERE_TEST) begin
                            state_reg <= ST_RUN;
                        end else begin
                            m_tvalid_reg <= 1'b1;
                            cause_reg    <= CAUSE_NONE;
                        end
                    end
                end
                ST_RUN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == AW'(NUM_CORNERS - 1)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!pv1_reg && !cv1_reg && !v2_reg) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        cause_reg    <= test_cause;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, cause_reg, cause_reg == CAUSE_NONE};

    // pipeline is empty whenever a new item may be taken
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!pv1_reg && !v2_reg))
        else $error("pipeline busy while idle");

    a_tready_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid_reg || m_tready))
        else $error("input taken while result slot is full");

    a_cause_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:1] != 2'd3))
        else $error("illegal cull cause");

    a_plane_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        pv1_reg |-> $past(cnt_reg < AW'(NUM_PLANES)))
        else $error("plane read past last plane");

endmodule

// ===== rtl/fbsc_ram.sv =====
// ----------------------------------------------------------------------------
// fbsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
